@@ rtl/core/sadl_pkg.sv @@
// shared types and constants for the slot allocator with dense live list
// no dependencies
`default_nettype none

package sadl_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   position;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_out;
        logic [COUNT_W-1:0]  live_count;
    } t_out_word;

endpackage

`default_nettype wire

@@ rtl/core/slot_allocator_dense_list.sv @@
// flow: allocate, clear and read go from ST_IDLE to ST_FETCH, then to the registered result;
//   release adds ST_CHECK; no new word is taken before ST_IDLE; the shared read port of the
//   dense list memory sets the release path: position map, then dense entry, then write back
// reset: counters cleared at once, memories need no clearing pass; liveness is
//   derived from the position map and dense list, so stale entries are never trusted
// depends on sadl_pkg
`default_nettype none

module slot_allocator_dense_list (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  sadl_pkg::t_in_word    i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output sadl_pkg::t_out_word   o_out_data
);

    localparam int AW = sadl_pkg::ADDR_W;
    localparam int CW = sadl_pkg::CNT_W;

    // memories
    logic [AW-1:0] stack_mem [sadl_pkg::POOL_SIZE];
    logic [AW-1:0] dense_mem [sadl_pkg::POOL_SIZE];
    logic [AW-1:0] pos_mem   [sadl_pkg::POOL_SIZE];

    logic [AW-1:0] r_stack_q, r_dense_q, r_pos_q;

    // control and counters
    sadl_pkg::t_state    r_state, n_state;
    sadl_pkg::t_in_word  r_req, n_req;
    logic [CW-1:0]       r_depth, n_depth;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [CW-1:0]       r_live, n_live;
    logic [AW-1:0]       r_last, n_last;
    logic [AW-1:0]       r_rpos, n_rpos;
    logic                r_cand, n_cand;
    logic                r_out_valid;
    sadl_pkg::t_out_word r_out;

    logic                fin;
    sadl_pkg::t_out_word res;
    logic                out_free;
    logic [AW-1:0]       alloc_slot;

    logic                rd_stack, rd_dense, rd_pos;
    logic [AW-1:0]       stack_raddr, dense_raddr, pos_raddr;
    logic                wr_stack, wr_dense, wr_pos;
    logic [AW-1:0]       stack_waddr, dense_waddr, pos_waddr;
    logic [AW-1:0]       stack_wdata, dense_wdata, pos_wdata;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != sadl_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign alloc_slot = (r_depth != '0) ? r_stack_q : r_fresh[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_depth = r_depth;
        n_fresh = r_fresh;
        n_live  = r_live;
        n_last  = r_last;
        n_rpos  = r_rpos;
        n_cand  = r_cand;
        fin     = 1'b0;
        res.status     = sadl_pkg::STS_OK;
        res.slot_out   = '0;
        res.live_count = r_live;
        rd_stack = 1'b0;
        rd_dense = 1'b0;
        rd_pos   = 1'b0;
        stack_raddr = r_depth[AW-1:0] - 1'b1;
        dense_raddr = r_live[AW-1:0] - 1'b1;
        pos_raddr   = i_in_data.slot;
        wr_stack = 1'b0;
        wr_dense = 1'b0;
        wr_pos   = 1'b0;
        stack_waddr = r_depth[AW-1:0];
        stack_wdata = r_req.slot;
        dense_waddr = r_live[AW-1:0];
        dense_wdata = alloc_slot;
        pos_waddr   = alloc_slot;
        pos_wdata   = r_live[AW-1:0];

        unique case (r_state)
            sadl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_req    = i_in_data;
                    rd_stack = 1'b1;
                    rd_dense = 1'b1;
                    rd_pos   = 1'b1;
                    // read uses the dense port for its entry, release for the tail
                    if (i_in_data.action == sadl_pkg::ACT_READ) begin
                        dense_raddr = i_in_data.position;
                    end
                    n_state = sadl_pkg::ST_FETCH;
                end
            end
            sadl_pkg::ST_FETCH: begin
                case (r_req.action)
                    sadl_pkg::ACT_ALLOC: begin
                        if (r_depth == '0 && r_fresh == CW'(sadl_pkg::POOL_SIZE)) begin
                            res.status = sadl_pkg::STS_FULL;
                            if (out_free) begin
                                fin     = 1'b1;
                                n_state = sadl_pkg::ST_IDLE;
                            end
                        end else if (out_free) begin
                            fin      = 1'b1;
                            wr_dense = 1'b1;
                            wr_pos   = 1'b1;
                            if (r_depth != '0) begin
                                n_depth = r_depth - 1'b1;
                            end else begin
                                n_fresh = r_fresh + 1'b1;
                            end
                            n_live         = r_live + 1'b1;
                            res.slot_out   = alloc_slot;
                            res.live_count = n_live;
                            n_state        = sadl_pkg::ST_IDLE;
                        end
                    end
                    sadl_pkg::ACT_RELEASE: begin
                        // tail slot held while the port fetches the slot's own entry
                        n_last      = r_dense_q;
                        n_rpos      = r_pos_q;
                        n_cand      = ({1'b0, r_req.slot} < r_fresh) &&
                                      ({1'b0, r_pos_q} < r_live);
                        rd_dense    = 1'b1;
                        dense_raddr = r_pos_q;
                        n_state     = sadl_pkg::ST_CHECK;
                    end
                    sadl_pkg::ACT_CLEAR: begin
                        if (out_free) begin
                            fin            = 1'b1;
                            n_depth        = '0;
                            n_fresh        = '0;
                            n_live         = '0;
                            res.live_count = '0;
                            n_state        = sadl_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if ({1'b0, r_req.position} < r_live) begin
                            res.slot_out = r_dense_q;
                        end else begin
                            res.status = sadl_pkg::STS_BAD;
                        end
                        if (out_free) begin
                            fin     = 1'b1;
                            n_state = sadl_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            sadl_pkg::ST_CHECK: begin
                // live only if the dense entry at its mapped position points back
                if (r_cand && r_dense_q == r_req.slot) begin
                    if (out_free) begin
                        fin            = 1'b1;
                        wr_stack       = 1'b1;
                        wr_dense       = 1'b1;
                        dense_waddr    = r_rpos;
                        dense_wdata    = r_last;
                        wr_pos         = 1'b1;
                        pos_waddr      = r_last;
                        pos_wdata      = r_rpos;
                        n_depth        = r_depth + 1'b1;
                        n_live         = r_live - 1'b1;
                        res.live_count = n_live;
                        n_state        = sadl_pkg::ST_IDLE;
                    end
                end else begin
                    res.status = sadl_pkg::STS_BAD;
                    if (out_free) begin
                        fin     = 1'b1;
                        n_state = sadl_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sadl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sadl_pkg::ST_IDLE;
            r_depth     <= '0;
            r_fresh     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            r_live  <= n_live;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_last <= n_last;
        r_rpos <= n_rpos;
        r_cand <= n_cand;
        if (fin) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_stack) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (rd_stack) begin
            r_stack_q <= stack_mem[stack_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_dense) begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
        if (rd_dense) begin
            r_dense_q <= dense_mem[dense_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pos) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (rd_pos) begin
            r_pos_q <= pos_mem[pos_raddr];
        end
    end

endmodule

`default_nettype wire
